/* rtl/core/nclf_pkg.sv */
// Package: shared types, constants and helpers for the nearest cluster leg finder.
`default_nettype none
package nclf_pkg;
    localparam int SCAN_DEPTH_DEF = 1024;
    localparam logic [15:0] START_SHORTEST_MM = 16'd1300;
    localparam int EXCL_LOW = 140;
    localparam int EXCL_HIGH = 410;
    // 0.0057596 * 4096 * 2^32 rounded: angle = (d * ANG_MUL + 2^31) >> 32
    localparam logic [36:0] ANG_MUL = 37'd101323954741;
    localparam int CFG_IDX_W = 3;
    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_EXCLUDE = 3'd1;
    localparam logic [2:0] CFG_MIN_RANGE = 3'd2;
    localparam logic [2:0] CFG_SCAN_LIMIT = 3'd3;
    localparam logic [2:0] CFG_WINDOW = 3'd4;
    localparam logic [2:0] CFG_OFFSET = 3'd5;
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] range_mm;
        logic        range_valid;
        logic        last_sample;
    } t_in_item;

    typedef struct packed {
        logic        right_found;
        logic [9:0]  right_index;
        logic [15:0] right_dist_mm;
        logic [15:0] right_angle;
        logic        left_found;
        logic [9:0]  left_index;
        logic [15:0] left_dist_mm;
        logic [15:0] left_angle;
        logic        aligned;
    } t_out_item;

    typedef struct packed {
        logic        enable;
        logic        exclude_middle;
        logic [15:0] min_range_mm;
        logic [15:0] scan_limit_mm;
        logic [15:0] cluster_window_mm;
        logic [9:0]  dist_offset_mm;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SIDE, ST_P1, ST_CHK1, ST_P2, ST_CHK2, ST_P3, ST_FIN, ST_NEXT, ST_OUT
    } t_state;

    typedef struct packed {
        logic load_side;   // set up range for current side
        logic clr_pass;    // restart sweep pointer
        logic step;        // process one sample
        logic latch;       // commit side result
    } t_cmd;

    typedef struct packed {
        logic sweep_done;
        logic short_ok;
        logic count_ok;
        logic hit;
    } t_sts;
endpackage
`default_nettype wire

/* rtl/core/nearest_cluster_leg_finder.sv */
// Top level: nearest cluster leg finder.
// Samples load one per cycle while busy is low; a sample marked last starts
// the search (when enabled), holding busy high for up to three sweeps of each
// unlatched half. One result strobe follows each completed scan; the receiver
// cannot stall it.
`default_nettype none
module nearest_cluster_leg_finder #(
    parameter int SCAN_DEPTH = nclf_pkg::SCAN_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire nclf_pkg::t_in_item   i_item,
    output logic                      o_valid,
    output nclf_pkg::t_out_item       o_item,
    input  wire logic                 i_cfg_we,
    input  wire logic [nclf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data
);
    nclf_pkg::t_cfg r_cfg;
    nclf_pkg::t_cmd cmd;
    nclf_pkg::t_sts sts;
    logic side, ctl_busy, done, scan_end, rl, ll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{1'b0, 1'b0, 16'd50, 16'd1200, 16'd100, 10'd28};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nclf_pkg::CFG_ENABLE:     r_cfg.enable <= i_cfg_data[0];
                nclf_pkg::CFG_EXCLUDE:    r_cfg.exclude_middle <= i_cfg_data[0];
                nclf_pkg::CFG_MIN_RANGE:  r_cfg.min_range_mm <= i_cfg_data;
                nclf_pkg::CFG_SCAN_LIMIT: r_cfg.scan_limit_mm <= i_cfg_data;
                nclf_pkg::CFG_WINDOW:     r_cfg.cluster_window_mm <= i_cfg_data;
                nclf_pkg::CFG_OFFSET:     r_cfg.dist_offset_mm <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    wire logic take = start && !busy;
    assign busy = ctl_busy || scan_end;

    nclf_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_scan_end(scan_end), .i_right_latched(rl),
        .i_left_latched(ll), .i_sts(sts), .o_cmd(cmd), .o_side(side),
        .o_busy(ctl_busy), .o_done(done)
    );

    nclf_dp #(.SCAN_DEPTH(SCAN_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_take(take), .i_item, .i_cfg(r_cfg), .i_cmd(cmd),
        .i_side(side), .i_done(done), .o_sts(sts), .o_scan_end(scan_end),
        .o_right_latched(rl), .o_left_latched(ll), .o_result(o_item)
    );

    assign o_valid = done;
endmodule
`default_nettype wire

/* rtl/core/nclf_ctrl.sv */
// Controller: sequences side setup, up to three passes per side and the result strobe.
`default_nettype none
module nclf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_scan_end,
    input  wire logic            i_right_latched,
    input  wire logic            i_left_latched,
    input  wire nclf_pkg::t_sts  i_sts,
    output nclf_pkg::t_cmd       o_cmd,
    output logic                 o_side,
    output logic                 o_busy,
    output logic                 o_done
);
    nclf_pkg::t_state r_state, n_state;
    logic r_side, n_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nclf_pkg::ST_IDLE;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
        end
    end

    always_comb begin
        n_state = r_state;
        n_side  = r_side;
        case (r_state)
            nclf_pkg::ST_IDLE: begin
                if (i_scan_end) begin
                    n_state = nclf_pkg::ST_SIDE;
                    n_side  = 1'b0;
                end
            end
            nclf_pkg::ST_SIDE: begin
                if ((r_side ? i_left_latched : i_right_latched)) n_state = nclf_pkg::ST_NEXT;
                else n_state = nclf_pkg::ST_P1;
            end
            nclf_pkg::ST_P1:   if (i_sts.sweep_done) n_state = nclf_pkg::ST_CHK1;
            nclf_pkg::ST_CHK1: n_state = i_sts.short_ok ? nclf_pkg::ST_P2 : nclf_pkg::ST_NEXT;
            nclf_pkg::ST_P2:   if (i_sts.sweep_done) n_state = nclf_pkg::ST_CHK2;
            nclf_pkg::ST_CHK2: n_state = i_sts.count_ok ? nclf_pkg::ST_P3 : nclf_pkg::ST_NEXT;
            nclf_pkg::ST_P3: begin
                if (i_sts.hit) n_state = nclf_pkg::ST_FIN;
                else if (i_sts.sweep_done) n_state = nclf_pkg::ST_NEXT;
            end
            nclf_pkg::ST_FIN:  n_state = nclf_pkg::ST_NEXT;
            nclf_pkg::ST_NEXT: begin
                if (r_side) n_state = nclf_pkg::ST_OUT;
                else begin
                    n_state = nclf_pkg::ST_SIDE;
                    n_side  = 1'b1;
                end
            end
            nclf_pkg::ST_OUT:  n_state = nclf_pkg::ST_IDLE;
            default:           n_state = nclf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            nclf_pkg::ST_IDLE: o_busy = 1'b0;
            nclf_pkg::ST_SIDE: o_cmd.load_side = 1'b1;
            nclf_pkg::ST_P1, nclf_pkg::ST_P2, nclf_pkg::ST_P3: o_cmd.step = 1'b1;
            nclf_pkg::ST_CHK1, nclf_pkg::ST_CHK2: o_cmd.clr_pass = 1'b1;
            nclf_pkg::ST_FIN:  o_cmd.latch = 1'b1;
            nclf_pkg::ST_OUT:  o_done = 1'b1;
            default: ;
        endcase
    end
    assign o_side = r_side;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double strobe");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |-> $past(r_state == nclf_pkg::ST_P3)) else $error("latch outside pass 3");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("multiple commands");
endmodule
`default_nettype wire

/* rtl/core/nclf_dp.sv */
// Datapath: scan store, sweep pointer, shortest/count/select and side results.
`default_nettype none
module nclf_dp #(
    parameter int SCAN_DEPTH = nclf_pkg::SCAN_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire nclf_pkg::t_in_item i_item,
    input  wire nclf_pkg::t_cfg    i_cfg,
    input  wire nclf_pkg::t_cmd    i_cmd,
    input  wire logic              i_side,
    input  wire logic              i_done,
    output nclf_pkg::t_sts         o_sts,
    output logic                   o_scan_end,
    output logic                   o_right_latched,
    output logic                   o_left_latched,
    output nclf_pkg::t_out_item    o_result
);
    localparam int AW = $clog2(SCAN_DEPTH);
    localparam int CW = AW + 1;

    logic [16:0]   r_mem [SCAN_DEPTH];
    logic [16:0]   r_rd;
    logic [CW-1:0] r_count, r_end, r_centre, r_hi, r_ptr, r_rd_idx;
    logic          r_rd_v;
    logic [15:0]   r_short;
    logic [16:0]   r_limit;
    logic [CW-1:0] r_n, r_seen;
    logic          r_rl, r_ll;
    logic [9:0]    r_ri, r_li;
    logic [15:0]   r_rdst, r_ldst, r_rang, r_lang;
    logic [CW-1:0] r_hit_idx;
    logic [15:0]   r_hit_rng;
    logic          r_scan_end;
    logic [CW-1:0] r_fetch;
    logic          r_fetch_v;
    logic [2:0]    r_pass;

    wire logic store = i_take && i_item.func == nclf_pkg::FUNC_SAMPLE && i_cfg.enable;

    // sample load
    always_ff @(posedge i_clk) begin
        if (store && r_count < CW'(SCAN_DEPTH)) r_mem[r_count[AW-1:0]] <= {i_item.range_valid, i_item.range_mm};
        r_rd <= r_mem[r_fetch[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_scan_end <= 1'b0;
            r_end <= '0;
        end else begin
            r_scan_end <= 1'b0;
            if (i_take && i_item.func == nclf_pkg::FUNC_SAMPLE) begin
                if (!i_cfg.enable) r_count <= '0;
                else if (i_item.last_sample) begin
                    r_end <= (r_count < CW'(SCAN_DEPTH)) ? r_count + 1'b1 : r_count;
                    r_count <= '0;
                    r_scan_end <= 1'b1;
                end else if (r_count < CW'(SCAN_DEPTH)) r_count <= r_count + 1'b1;
            end
        end
    end
    assign o_scan_end = r_scan_end;

    wire logic excl = i_cfg.exclude_middle && 32'(r_rd_idx) > 32'(nclf_pkg::EXCL_LOW)
                      && 32'(r_rd_idx) < 32'(nclf_pkg::EXCL_HIGH);
    wire logic use_ok = r_rd_v && !excl && r_rd[16] && r_rd[15:0] > i_cfg.min_range_mm;
    wire logic in_win = {1'b0, r_rd[15:0]} < r_limit;
    wire logic [CW-1:0] kth = r_n >> 1;

    // sweep: fetch pointer, registered read, evaluate
    wire logic [CW-1:0] lo = i_side ? r_centre : '0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch_v <= 1'b0;
            r_rd_v <= 1'b0;
            r_pass <= '0;
        end else begin
            if (r_scan_end) r_centre <= r_end >> 1;
            if (i_cmd.load_side) begin
                r_fetch <= lo;
                r_hi <= i_side ? r_end : r_centre;
                r_fetch_v <= 1'b1;
                r_pass <= 3'd1;
                r_short <= nclf_pkg::START_SHORTEST_MM;
                r_n <= '0;
                r_seen <= '0;
                r_rd_v <= 1'b0;
            end else if (i_cmd.clr_pass) begin
                r_fetch <= lo;
                r_fetch_v <= 1'b1;
                r_rd_v <= 1'b0;
                r_pass <= r_pass << 1;
                r_limit <= {1'b0, r_short} + {1'b0, i_cfg.cluster_window_mm};
            end else if (i_cmd.step) begin
                r_rd_v <= r_fetch_v && r_fetch < r_hi;
                r_rd_idx <= r_fetch;
                if (r_fetch < r_hi) r_fetch <= r_fetch + 1'b1;
                else r_fetch_v <= 1'b0;
                if (use_ok) begin
                    if (r_pass[0] && r_rd[15:0] < r_short) r_short <= r_rd[15:0];
                    if (r_pass[1] && in_win) r_n <= r_n + 1'b1;
                    if (r_pass[2] && in_win) begin
                        r_seen <= r_seen + 1'b1;
                        r_hit_idx <= r_rd_idx;
                        r_hit_rng <= r_rd[15:0];
                    end
                end
            end
        end
    end

    assign o_sts.sweep_done = !r_fetch_v && !r_rd_v;
    assign o_sts.short_ok   = r_short < i_cfg.scan_limit_mm;
    assign o_sts.count_ok   = r_n > CW'(2);
    assign o_sts.hit        = i_cmd.step && r_pass[2] && use_ok && in_win && r_seen == kth;

    // result compute in latch cycle
    wire logic [CW-1:0] diff_r = r_centre - r_hit_idx;
    wire logic [CW-1:0] diff_l = r_hit_idx - r_centre;
    wire logic [CW-1:0] mag = i_side ? diff_l : diff_r;
    wire logic [63:0]   prod = 64'(mag) * 64'(nclf_pkg::ANG_MUL) + 64'h0000_0000_8000_0000;
    wire logic [31:0]   qv = prod[63:32];
    wire logic [15:0]   ang = (qv > 32'd32767) ? 16'h7FFF : qv[15:0];
    wire logic [16:0]   dsum = {1'b0, r_hit_rng} + 17'(i_cfg.dist_offset_mm);
    wire logic [15:0]   dist_sat = dsum[16] ? 16'hFFFF : dsum[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rl <= 1'b0;
            r_ll <= 1'b0;
        end else if (i_take && i_item.func == nclf_pkg::FUNC_RESTART) begin
            r_rl <= 1'b0;
            r_ll <= 1'b0;
        end else if (i_cmd.latch) begin
            if (i_side) begin
                r_ll <= 1'b1; r_li <= 10'(r_hit_idx); r_ldst <= dist_sat; r_lang <= ang;
            end else begin
                r_rl <= 1'b1; r_ri <= 10'(r_hit_idx); r_rdst <= dist_sat; r_rang <= ang;
            end
        end
    end
    assign o_right_latched = r_rl;
    assign o_left_latched  = r_ll;

    always_comb begin
        o_result.right_found   = r_rl;
        o_result.right_index   = r_rl ? r_ri : '0;
        o_result.right_dist_mm = r_rl ? r_rdst : '0;
        o_result.right_angle   = r_rl ? r_rang : '0;
        o_result.left_found    = r_ll;
        o_result.left_index    = r_ll ? r_li : '0;
        o_result.left_dist_mm  = r_ll ? r_ldst : '0;
        o_result.left_angle    = r_ll ? r_lang : '0;
        o_result.aligned       = r_rl && r_ll && i_done;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.latch |-> r_pass[2]) else $error("latch without select pass");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_pass)) else $error("pass code broken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SCAN_DEPTH)) else $error("count overflow");
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Testbench: random and directed scans against a behavioral leg finder predictor.
`default_nettype none
module testbench;
    import nclf_pkg::*;

    localparam int DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 830;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_item i_item = '0;
    logic o_valid;
    t_out_item o_item;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    nearest_cluster_leg_finder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_item(o_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    t_cfg cfg_m;
    logic [16:0] scan_m [DEPTH];
    int unsigned count_m;
    logic r_lat, l_lat;
    logic [9:0] r_idx, l_idx;
    logic [15:0] r_dist, l_dist, r_ang, l_ang;

    t_in_item pending_items[$];
    t_out_item expected_results[$];
    int errors = 0;
    int watchdog = 0;
    bit hold_off = 1'b0;
    int burst_left = 0;
    int gap_left = 0;

    function automatic logic [15:0] angle_of(longint d);
        longint mag, q;
        mag = d < 0 ? -d : d;
        q = (mag * 64'd235913216 + 64'd5000000) / 64'd10000000;
        if (d < 0) return (q > 32768) ? 16'h8000 : 16'(-q);
        return (q > 32767) ? 16'h7fff : 16'(q);
    endfunction

    function automatic bit usable(int unsigned i, output int unsigned r);
        r = scan_m[i][15:0];
        if (cfg_m.exclude_middle && i > EXCL_LOW && i < EXCL_HIGH) return 0;
        if (!scan_m[i][16]) return 0;
        return r > cfg_m.min_range_mm;
    endfunction

    function automatic bit search_half(int unsigned lo, int unsigned hi, int unsigned c,
                                       bit right, output logic [9:0] idx,
                                       output logic [15:0] dst, output logic [15:0] ang);
        int unsigned shortest, lim, n, k, seen, r, d;
        shortest = 1300; n = 0; seen = 0;
        idx = '0; dst = '0; ang = '0;
        for (int unsigned i = lo; i < hi; i++)
            if (usable(i, r) && r < shortest) shortest = r;
        if (!(shortest < cfg_m.scan_limit_mm)) return 0;
        lim = shortest + cfg_m.cluster_window_mm;
        for (int unsigned i = lo; i < hi; i++)
            if (usable(i, r) && r < lim) n++;
        if (n <= 2) return 0;
        k = n / 2;
        for (int unsigned i = lo; i < hi; i++) begin
            if (usable(i, r) && r < lim) begin
                if (seen == k) begin
                    d = r + cfg_m.dist_offset_mm;
                    idx = i[9:0];
                    dst = d > 65535 ? 16'hffff : d[15:0];
                    ang = angle_of(right ? longint'(c) - longint'(i)
                                         : longint'(i) - longint'(c));
                    return 1;
                end
                seen++;
            end
        end
        return 0;
    endfunction

    task automatic predict_item(t_in_item it);
        int unsigned c;
        logic [9:0] ix;
        logic [15:0] ds, an;
        t_out_item res;
        if (it.func == FUNC_RESTART) begin
            r_lat = 0; l_lat = 0;
            return;
        end
        if (!cfg_m.enable) begin
            count_m = 0;
            return;
        end
        if (count_m < DEPTH) begin
            scan_m[count_m] = {it.range_valid, it.range_mm};
            count_m++;
        end
        if (!it.last_sample) return;
        c = count_m / 2;
        if (!r_lat && search_half(0, c, c, 1, ix, ds, an)) begin
            r_lat = 1; r_idx = ix; r_dist = ds; r_ang = an;
        end
        if (!l_lat && search_half(c, count_m, c, 0, ix, ds, an)) begin
            l_lat = 1; l_idx = ix; l_dist = ds; l_ang = an;
        end
        count_m = 0;
        res = '0;
        if (r_lat) begin
            res.right_found = 1; res.right_index = r_idx;
            res.right_dist_mm = r_dist; res.right_angle = r_ang;
        end
        if (l_lat) begin
            res.left_found = 1; res.left_index = l_idx;
            res.left_dist_mm = l_dist; res.left_angle = l_ang;
        end
        res.aligned = r_lat && l_lat;
        expected_results.push_back(res);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_item(i_item);
                void'(pending_items.pop_front());
            end
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 60);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
            if (pending_items.size() > 0 && !hold_off && gap_left == 0) begin
                start <= 1'b1;
                i_item <= pending_items[0];
                if (!(start && busy)) burst_left--;
            end else begin
                start <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) watchdog <= 0;
            else watchdog <= watchdog + 1;
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %p", o_item);
                    errors++;
                end else begin
                    t_out_item e;
                    e = expected_results.pop_front();
                    if (e.right_found !== o_item.right_found) begin
                        $error("right_found exp %0d got %0d", e.right_found, o_item.right_found); errors++; end
                    if (e.right_index !== o_item.right_index) begin
                        $error("right_index exp %0d got %0d", e.right_index, o_item.right_index); errors++; end
                    if (e.right_dist_mm !== o_item.right_dist_mm) begin
                        $error("right_dist_mm exp %0d got %0d", e.right_dist_mm, o_item.right_dist_mm); errors++; end
                    if (e.right_angle !== o_item.right_angle) begin
                        $error("right_angle exp %0d got %0d", $signed(e.right_angle), $signed(o_item.right_angle)); errors++; end
                    if (e.left_found !== o_item.left_found) begin
                        $error("left_found exp %0d got %0d", e.left_found, o_item.left_found); errors++; end
                    if (e.left_index !== o_item.left_index) begin
                        $error("left_index exp %0d got %0d", e.left_index, o_item.left_index); errors++; end
                    if (e.left_dist_mm !== o_item.left_dist_mm) begin
                        $error("left_dist_mm exp %0d got %0d", e.left_dist_mm, o_item.left_dist_mm); errors++; end
                    if (e.left_angle !== o_item.left_angle) begin
                        $error("left_angle exp %0d got %0d", $signed(e.left_angle), $signed(o_item.left_angle)); errors++; end
                    if (e.aligned !== o_item.aligned) begin
                        $error("aligned exp %0d got %0d", e.aligned, o_item.aligned); errors++; end
                end
            end
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic t_in_item sample(logic [15:0] r, logic v, logic last);
        t_in_item it;
        it.func = FUNC_SAMPLE; it.range_mm = r; it.range_valid = v; it.last_sample = last;
        return it;
    endfunction

    function automatic t_in_item restart_item();
        t_in_item it;
        it = sample(16'($urandom), 1'($urandom), 1'($urandom));
        it.func = FUNC_RESTART;
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || expected_results.size() > 0 || start)
            @(posedge i_clk);
        repeat (3200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        case (idx)
            CFG_ENABLE:     cfg_m.enable = val[0];
            CFG_EXCLUDE:    cfg_m.exclude_middle = val[0];
            CFG_MIN_RANGE:  cfg_m.min_range_mm = val;
            CFG_SCAN_LIMIT: cfg_m.scan_limit_mm = val;
            CFG_WINDOW:     cfg_m.cluster_window_mm = val;
            CFG_OFFSET:     cfg_m.dist_offset_mm = val[9:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // scan with a near cluster around a random spot, plus background
    task automatic queue_scan(int len, bit restart_first);
        int cpos, cw, base;
        if (restart_first) pending_items.push_back(restart_item());
        cpos = $urandom_range(0, len - 1);
        cw = $urandom_range(0, 12);
        base = $urandom_range(60, 1250);
        for (int i = 0; i < len; i++) begin
            logic [15:0] r;
            logic v;
            v = ($urandom_range(0, 15) != 0);
            if ((i >= cpos && i < cpos + cw) || ($urandom_range(0, 9) == 0 && i > len / 2 &&
                i < len / 2 + cw))
                r = 16'(base + $urandom_range(0, 150));
            else if ($urandom_range(0, 20) == 0)
                r = 16'($urandom);
            else
                r = 16'($urandom_range(900, 4000));
            pending_items.push_back(sample(r, v, i == len - 1));
        end
    endtask

    task automatic random_config();
        write_reg(CFG_EXCLUDE, 16'($urandom_range(0, 3) == 0));
        write_reg(CFG_MIN_RANGE, 16'($urandom_range(0, 120)));
        write_reg(CFG_SCAN_LIMIT,
                  16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(600, 1400)));
        write_reg(CFG_WINDOW,
                  16'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 300)));
        write_reg(CFG_OFFSET, 16'($urandom_range(0, 1023)));
    endtask

    initial begin
        int sent;
        cfg_m = '{enable: 0, exclude_middle: 0, min_range_mm: 50, scan_limit_mm: 1200,
                  cluster_window_mm: 100, dist_offset_mm: 28};
        count_m = 0; r_lat = 0; l_lat = 0;
        {r_idx, l_idx, r_dist, l_dist, r_ang, l_ang} = '0;
        for (int i = 0; i < DEPTH; i++) scan_m[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled: samples, including one marked last, are ignored
        pending_items.push_back(sample(16'd100, 1'b1, 1'b0));
        pending_items.push_back(sample(16'd100, 1'b1, 1'b1));
        drain();
        write_reg(CFG_ENABLE, 16'd1);
        // extremes and a clear cluster on both sides
        for (int i = 0; i < 8; i++)
            pending_items.push_back(sample(16'(i < 4 ? 400 + i : 500 + i), 1'b1, 1'b0));
        pending_items.push_back(sample(16'hffff, 1'b1, 1'b0));
        pending_items.push_back(sample(16'd0, 1'b1, 1'b0));
        pending_items.push_back(sample(16'd300, 1'b0, 1'b0));
        pending_items.push_back(sample(16'd510, 1'b1, 1'b1));
        pending_items.push_back(sample(16'd200, 1'b1, 1'b1));   // one-sample scan
        pending_items.push_back(restart_item());
        pending_items.push_back(sample(16'd0, 1'b0, 1'b1));
        drain();
        // saturation of distance, odd extremes
        write_reg(CFG_OFFSET, 16'd1023);
        write_reg(CFG_MIN_RANGE, 16'd0);
        write_reg(CFG_SCAN_LIMIT, 16'hffff);
        write_reg(CFG_WINDOW, 16'hffff);
        pending_items.push_back(restart_item());
        queue_scan(12, 0);
        drain();
        write_reg(CFG_MIN_RANGE, 16'hffff);
        write_reg(CFG_WINDOW, 16'd0);
        write_reg(CFG_SCAN_LIMIT, 16'd0);
        queue_scan(6, 1);
        drain();
        // overfull scan with exclusion, all samples near
        write_reg(CFG_MIN_RANGE, 16'd50);
        write_reg(CFG_SCAN_LIMIT, 16'd1200);
        write_reg(CFG_WINDOW, 16'd100);
        write_reg(CFG_EXCLUDE, 16'd1);
        pending_items.push_back(restart_item());
        for (int i = 0; i < DEPTH + 6; i++)
            pending_items.push_back(sample(16'(300 + (i % 90)), 1'b1, i == DEPTH + 5));
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            random_config();
            for (int s = 0; s < 6 && sent < RANDOM_ITEMS; s++) begin
                int len;
                len = $urandom_range(0, 9) == 0 ? $urandom_range(280, 600) : $urandom_range(1, 40);
                queue_scan(len, $urandom_range(0, 2) == 0);
                sent += len;
                if ($urandom_range(0, 9) == 0)
                    pending_items.push_back(restart_item());
            end
            if ($urandom_range(0, 4) == 0) begin
                // pause the sender until everything is out
                hold_off = 1'b0;
                while (pending_items.size() > 0 || start) @(posedge i_clk);
                hold_off = 1'b1;
                while (expected_results.size() > 0) @(posedge i_clk);
                hold_off = 1'b0;
            end
            if ($urandom_range(0, 5) == 0) begin
                drain();
                write_reg(CFG_ENABLE, 16'd0);
                queue_scan($urandom_range(1, 10), 0);
                pending_items.push_back(sample(16'($urandom), 1'($urandom), 1'b0));
                drain();
                write_reg(CFG_ENABLE, 16'd1);
            end
            drain();
        end
        drain();
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
